### rtl/assert_macros.svh
// Assertion macros used by the top level of the color balance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/tpcb_pkg.sv
// Types and constants shared by the color balance lanes and top level.
package tpcb_pkg;

    localparam int PT_W     = 9;
    localparam int CODE_W   = 8;
    localparam int COL_W    = 12;
    localparam int CFG_W    = 27;
    localparam int FW_W     = 13;
    localparam int NUM_LANES = 3;
    localparam int LANE_LAT = 15;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_BLACK  = 3'd0,
        REG_GRAY   = 3'd1,
        REG_WHITE  = 3'd2,
        REG_SPLIT  = 3'd3,
        REG_SRCL   = 3'd4,
        REG_WIDTH  = 3'd5
    } cfg_idx_t;

    // Three curve points of one channel, units of 1/256.
    typedef struct packed {
        logic [PT_W-1:0] black;
        logic [PT_W-1:0] gray;
        logic [PT_W-1:0] white;
    } pts_t;

    // Lane result: pass means the curve is undefined and the code is kept.
    typedef struct packed {
        logic              pass;
        logic [CODE_W-1:0] val;
    } lane_res_t;

endpackage

### rtl/tpcb_lane.sv
// One channel lane: exact parabola evaluation, clamp and pipelined divide.
module tpcb_lane (
    input  logic                        clk,
    input  logic                        en,
    input  tpcb_pkg::pts_t              pts,
    input  logic [tpcb_pkg::CODE_W-1:0] code,
    output tpcb_pkg::lane_res_t         res
);
    import tpcb_pkg::*;

    localparam int QB = 8;

    // Points scaled by 255.
    logic [16:0] bs, gs, ws;
    logic        deg;

    logic signed [17:0] gb_reg, wb_reg, gw_reg, wb2_reg;
    logic        [16:0] g1_reg, w1_reg;
    logic signed [19:0] a_reg;
    logic signed [35:0] gprod, wprod, dgprod;
    logic signed [37:0] c_reg;
    logic signed [36:0] d0_reg;
    logic signed [54:0] dprod;
    logic               dneg_reg;
    logic        [53:0] dabs_reg;

    logic        [15:0] x1_reg;
    logic signed [18:0] xb1_reg, xb2_reg, xb3_reg;
    logic signed [36:0] xa2_reg;
    logic signed [38:0] l3_reg;
    logic signed [57:0] n4_reg, n5_reg;
    logic [5:1]         deg_reg;

    logic [61:0]        rem_reg [0:QB];
    logic [QB-1:0]      q_reg   [0:QB];
    logic [QB:0]        zero_reg, sat_reg, pdeg_reg;
    lane_res_t          res_reg;

    assign bs  = {pts.black, 8'b0} - 17'(pts.black);
    assign gs  = {pts.gray, 8'b0} - 17'(pts.gray);
    assign ws  = {pts.white, 8'b0} - 17'(pts.white);
    assign deg = (pts.black == pts.gray) || (pts.gray == pts.white) ||
                 (pts.black == pts.white);

    // Curve constants that depend on the points only.
    assign gprod  = $signed({1'b0, g1_reg}) * gb_reg;
    assign wprod  = $signed({1'b0, w1_reg}) * wb_reg;
    assign dgprod = gb_reg * gw_reg;
    assign dprod  = d0_reg * wb2_reg;

    always_ff @(posedge clk)
    begin
        gb_reg   <= $signed({1'b0, gs}) - $signed({1'b0, bs});
        wb_reg   <= $signed({1'b0, ws}) - $signed({1'b0, bs});
        gw_reg   <= $signed({1'b0, gs}) - $signed({1'b0, ws});
        g1_reg   <= gs;
        w1_reg   <= ws;
        a_reg    <= $signed({3'b0, bs}) + $signed({3'b0, ws}) - $signed({2'b0, gs, 1'b0});
        c_reg    <= (38'(gprod) <<< 1) - 38'(wprod);
        d0_reg   <= 37'(dgprod) <<< 1;
        wb2_reg  <= wb_reg;
        dneg_reg <= dprod[54];
        dabs_reg <= dprod[54] ? 54'(-dprod) : 54'(dprod);
    end

    // Numerator N = (X-b) * (X*(b+w-2g) + 2g(g-b) - w(w-b)), sign set by D.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg     <= {code, 8'b0};
            xb1_reg    <= $signed({3'b0, code, 8'b0}) - $signed({2'b0, bs});
            deg_reg[1] <= deg;
            xa2_reg    <= $signed({1'b0, x1_reg}) * a_reg;
            xb2_reg    <= xb1_reg;
            deg_reg[2] <= deg_reg[1];
            l3_reg     <= 39'(xa2_reg) + 39'(c_reg);
            xb3_reg    <= xb2_reg;
            deg_reg[3] <= deg_reg[2];
            n4_reg     <= 58'(xb3_reg) * 58'(l3_reg);
            deg_reg[4] <= deg_reg[3];
            n5_reg     <= dneg_reg ? -n4_reg : n4_reg;
            deg_reg[5] <= deg_reg[4];
        end
    end

    // Clamp tests and restoring divide of 255*N by D, one quotient bit a stage.
    always_ff @(posedge clk)
    begin
        logic [62:0] trial;
        if (en)
        begin
            zero_reg[0] <= n5_reg[57] || (n5_reg == '0);
            sat_reg[0]  <= n5_reg >= $signed({4'b0, dabs_reg});
            pdeg_reg[0] <= deg_reg[5];
            rem_reg[0]  <= {n5_reg[53:0], 8'b0} - 62'(n5_reg[53:0]);
            q_reg[0]    <= '0;
            for (int s = 0; s < QB; s++)
            begin
                trial = {1'b0, rem_reg[s]} - {1'b0, 62'(dabs_reg) << (QB - 1 - s)};
                zero_reg[s+1] <= zero_reg[s];
                sat_reg[s+1]  <= sat_reg[s];
                pdeg_reg[s+1] <= pdeg_reg[s];
                if (!trial[62])
                begin
                    rem_reg[s+1] <= trial[61:0];
                    q_reg[s+1]   <= q_reg[s] | QB'(1 << (QB - 1 - s));
                end
                else
                begin
                    rem_reg[s+1] <= rem_reg[s];
                    q_reg[s+1]   <= q_reg[s];
                end
            end
            res_reg.pass <= pdeg_reg[QB];
            if (zero_reg[QB])
                res_reg.val <= '0;
            else if (sat_reg[QB])
                res_reg.val <= '1;
            else
                res_reg.val <= q_reg[QB];
        end
    end

    assign res = res_reg;

endmodule

### rtl/three_point_color_balance.sv
// Top level of the three-point color balance block: config, lanes, merge.
// One RGBA pixel is taken every clock while the output side accepts; a pixel
// passes through the 15 lane stages, set by the multiply chain and the
// eight-stage quotient pipeline, and then the output register to the output.
// The whole pipeline holds while a result waits on the output.
// Configuration writes are always ready and take effect for pixels accepted
// from the next cycle on.
module three_point_color_balance #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // column, in_red, in_green, in_blue, in_alpha, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [26:0] cfg_data
);
    import tpcb_pkg::*;
    `include "assert_macros.svh"

    localparam int LAT = LANE_LAT;
    localparam logic [FW_W:0] MAXW_C =
        (MAX_WIDTH > 8191) ? (FW_W+1)'(8191) : (FW_W+1)'(MAX_WIDTH);

    logic [CFG_W-1:0] black_reg, gray_reg, white_reg;
    logic             split_reg, srcl_reg;
    logic [FW_W-1:0]  width_reg;

    logic [FW_W-1:0]  width_eff;
    logic [COL_W-1:0] half, col;
    logic             copy, en;

    logic [CODE_W-1:0] in_code [0:NUM_LANES-1];
    logic [LAT-1:0]    vld_reg;
    logic [LAT-1:0]    copy_line;
    logic [CODE_W-1:0] alpha_line [0:LAT-1];
    logic [CODE_W-1:0] code_line  [0:LAT-1][0:NUM_LANES-1];
    lane_res_t         lres [0:NUM_LANES-1];

    logic              m_valid_reg;
    logic [CODE_W-1:0] out_code_reg [0:NUM_LANES-1];
    logic [CODE_W-1:0] out_alpha_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg <= '0;
            gray_reg  <= 27'd33620096;
            white_reg <= 27'd67240192;
            split_reg <= 1'b1;
            srcl_reg  <= 1'b1;
            width_reg <= 13'd640;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_BLACK: black_reg <= cfg_data;
                REG_GRAY:  gray_reg  <= cfg_data;
                REG_WHITE: white_reg <= cfg_data;
                REG_SPLIT: split_reg <= cfg_data[0];
                REG_SRCL:  srcl_reg  <= cfg_data[0];
                REG_WIDTH: width_reg <= cfg_data[FW_W-1:0];
                default:   ;
            endcase
        end
    end

    // Split preview decision.
    assign width_eff = ({1'b0, width_reg} > MAXW_C) ? MAXW_C[FW_W-1:0] : width_reg;
    assign half      = width_eff[FW_W-1:1];
    assign col       = s_tdata[COL_W-1:0];
    assign copy      = split_reg && ((srcl_reg && (col < half)) ||
                                     (!srcl_reg && (col >= half)));

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // One lane per color channel; red sits in the top bits of the points.
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        pts_t pts;
        assign in_code[i] = s_tdata[COL_W + i*CODE_W +: CODE_W];
        assign pts.black  = black_reg[(NUM_LANES-1-i)*PT_W +: PT_W];
        assign pts.gray   = gray_reg[(NUM_LANES-1-i)*PT_W +: PT_W];
        assign pts.white  = white_reg[(NUM_LANES-1-i)*PT_W +: PT_W];
        tpcb_lane u_lane (
            .clk  (clk),
            .en   (en),
            .pts  (pts),
            .code (in_code[i]),
            .res  (lres[i])
        );
    end

    // Side data traveling beside the lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            copy_line[0]  <= copy;
            alpha_line[0] <= s_tdata[COL_W + NUM_LANES*CODE_W +: CODE_W];
            for (int i = 0; i < NUM_LANES; i++)
                code_line[0][i] <= in_code[i];
            for (int s = 1; s < LAT; s++)
            begin
                copy_line[s]  <= copy_line[s-1];
                alpha_line[s] <= alpha_line[s-1];
                for (int i = 0; i < NUM_LANES; i++)
                    code_line[s][i] <= code_line[s-1][i];
            end
        end
    end

    // Merge stage: copied or undefined channels keep their code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= vld_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_alpha_reg <= alpha_line[LAT-1];
            for (int i = 0; i < NUM_LANES; i++)
                out_code_reg[i] <= (copy_line[LAT-1] || lres[i].pass) ?
                                   code_line[LAT-1][i] : lres[i].val;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_alpha_reg, out_code_reg[2], out_code_reg[1], out_code_reg[0]};

    `ASSERT_NEXT(a_copy_red, clk, rst_n, en && vld_reg[LAT-1] && copy_line[LAT-1], m_tdata[7:0] == $past(code_line[LAT-1][0]), "copied red code altered")
    `ASSERT_NEXT(a_advance, clk, rst_n, en && vld_reg[LAT-1], m_tvalid, "finished pixel lost at merge")
    `ASSERT_NEXT(a_alpha, clk, rst_n, en && vld_reg[LAT-1], m_tdata[31:24] == $past(alpha_line[LAT-1]), "alpha altered")

endmodule
